// ----- src/assert_macros.svh -----
// Assertion macros shared by the face size histogram binner RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold at every edge out of reset.
`define FSHB_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("fshb assertion failed");

// Antecedent on one edge implies consequent on the next edge.
`define FSHB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fshb assertion failed");

`endif

// ----- src/fshb_pkg.sv -----
// Package for the face size histogram binner: command/result types, states.
// Depends on nothing.
package fshb_pkg;

  localparam int MAX_BINS   = 64;
  localparam int BIN_AW     = 6;
  localparam int SIZE_W     = 6;
  localparam int TOL_W      = 16;
  localparam int OUT_CNT_W  = 20;
  localparam int TOT_W      = 7;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLAVE  = 2'd1;

  localparam logic [TOL_W-1:0] MASTER_RST = 16'd307;
  localparam logic [TOL_W-1:0] SLAVE_RST  = 16'd282;
  localparam logic [TOL_W-1:0] SLAVE_MIN  = 16'd256;

  typedef enum logic [2:0] {
    OP_ADD, OP_BUILD, OP_MAP, OP_QUERY, OP_CLEAR, OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              size_bad;
    logic [SIZE_W-1:0] fsz;
    logic [SIZE_W-1:0] bin_number;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    bin_index;
    logic [SIZE_W-1:0]    bin_max_size;
    logic [OUT_CNT_W-1:0] bin_face_count;
    logic [TOT_W-1:0]     total_bins;
    logic                 last;
    logic                 overflow;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_WR, S_BM1, S_BM2, S_BCMP,
    S_WRD, S_WEV, S_WM1, S_WM2, S_WCMP, S_WACC, S_WEND,
    S_DISP, S_ERD, S_EOUT, S_MRD, S_MCHK, S_QRD, S_QOUT, S_EMIT
  } st_t;

endpackage

// ----- src/fshb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fshb_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- src/fshb_front.sv -----
// Front end: accepts input items, decodes the kind, queues two commands.
// Depends on fshb_pkg.
module fshb_front #(
  parameter int SIZE_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [fshb_pkg::KIND_W-1:0] in_kind,
  input  logic [fshb_pkg::SIZE_W-1:0] in_face_size,
  input  logic [fshb_pkg::SIZE_W-1:0] in_bin_number,
  output logic                       cmd_valid,
  output fshb_pkg::cmd_t             cmd,
  input  logic                       cmd_pop
);
  fshb_pkg::cmd_t q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  fshb_pkg::cmd_t dec;
  logic push_ok;

  always_comb begin
    dec.fsz        = in_face_size;
    dec.bin_number = in_bin_number;
    dec.size_bad   = ({1'b0, in_face_size} >= 7'(SIZE_SLOTS));
    unique case (in_kind)
      fshb_pkg::KIND_ADD:   dec.op = fshb_pkg::OP_ADD;
      fshb_pkg::KIND_BUILD: dec.op = fshb_pkg::OP_BUILD;
      fshb_pkg::KIND_MAP:   dec.op = fshb_pkg::OP_MAP;
      fshb_pkg::KIND_QUERY: dec.op = fshb_pkg::OP_QUERY;
      fshb_pkg::KIND_CLEAR: dec.op = fshb_pkg::OP_CLEAR;
      default:              dec.op = fshb_pkg::OP_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= dec;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) begin
        wp_r <= ~wp_r;
      end
      if (cmd_pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push_ok) - 2'(cmd_pop);
    end
  end
endmodule

// ----- src/fshb_back.sv -----
// Back end sequencer: histogram update, bin build walk, bin emission/queries.
// Depends on fshb_pkg, fshb_ram and assert_macros.svh.
`include "assert_macros.svh"
module fshb_back #(
  parameter int SIZE_SLOTS = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  fshb_pkg::cmd_t              cmd,
  output logic                        cmd_pop,
  input  logic [fshb_pkg::TOL_W-1:0]  master_tol,
  input  logic [fshb_pkg::TOL_W-1:0]  slave_tol,
  output logic                        res_valid,
  output fshb_pkg::res_t              res,
  input  logic                        res_ready
);
  localparam int SB  = $clog2(SIZE_SLOTS);
  localparam int CB  = COUNT_BITS;
  localparam int SW  = CB + 6;
  localparam int PAW = CB + 6;
  localparam int PBW = fshb_pkg::TOL_W + SW;
  localparam int BW  = fshb_pkg::SIZE_W + CB;

  fshb_pkg::st_t st_r, st_nxt;
  fshb_pkg::cmd_t cmd_r, cmd_nxt;
  logic [SIZE_SLOTS-1:0] vld_r, vld_nxt;
  logic [CB-1:0]  faces_r, faces_nxt, run_cnt_r, run_cnt_nxt, c_r, c_nxt;
  logic [SW-1:0]  sum_r, sum_nxt, run_sum_r, run_sum_nxt;
  logic [5:0]     largest_r, largest_nxt, prev_r, prev_nxt;
  logic [fshb_pkg::TOT_W-1:0] stored_r, stored_nxt;
  logic           built_r, built_nxt, dropped_r, dropped_nxt;
  logic [SB-1:0]  s_r, s_nxt;
  logic [fshb_pkg::BIN_AW-1:0] i_r, i_nxt;
  logic [PAW-1:0] pa_r, pa_nxt;
  logic [PBW-1:0] pb_r, pb_nxt;
  logic [5:0]     ridx_r, ridx_nxt, rsz_r, rsz_nxt;
  logic [CB-1:0]  rcnt_r, rcnt_nxt;
  logic           rlast_r, rlast_nxt;

  logic           cw_we, c_re;
  logic [SB-1:0]  cw_addr, cr_addr, vld_addr;
  logic [CB-1:0]  cw_data, c_rdata;
  logic           bw_we, b_re;
  logic [fshb_pkg::BIN_AW-1:0] bw_addr, br_addr;
  logic [BW-1:0]  bw_data, b_rdata;

  logic [CB-1:0]  slot_cnt;
  logic [5:0]     b_size, s_val;
  logic [CB-1:0]  b_cnt;
  logic [fshb_pkg::TOL_W-1:0] slave_eff;
  logic           ratio_gt, slot_last, store_room, drop_add;

  fshb_ram #(.W(CB), .D(SIZE_SLOTS)) u_counts (
    .clk, .we(cw_we), .waddr(cw_addr), .wdata(cw_data),
    .re(c_re), .raddr(cr_addr), .rdata(c_rdata)
  );
  fshb_ram #(.W(BW), .D(fshb_pkg::MAX_BINS)) u_bins (
    .clk, .we(bw_we), .waddr(bw_addr), .wdata(bw_data),
    .re(b_re), .raddr(br_addr), .rdata(b_rdata)
  );

  assign cr_addr    = (st_r == fshb_pkg::S_IDLE) ? cmd.fsz[SB-1:0] : s_r;
  // slot whose count is on c_rdata: the add's slot during the write-back
  assign vld_addr   = (st_r == fshb_pkg::S_ADD_WR) ? cmd_r.fsz[SB-1:0] : cr_addr;
  assign slot_cnt   = vld_r[vld_addr] ? c_rdata : '0;
  assign b_size     = b_rdata[BW-1 -: 6];
  assign b_cnt      = b_rdata[CB-1:0];
  assign s_val      = 6'(s_r);
  assign slave_eff  = (slave_tol < fshb_pkg::SLAVE_MIN) ? fshb_pkg::SLAVE_MIN : slave_tol;
  assign ratio_gt   = (PBW'({pa_r, 8'b0}) > pb_r);
  assign slot_last  = (s_r == SB'(SIZE_SLOTS - 1));
  assign store_room = (stored_r < 7'(fshb_pkg::MAX_BINS));
  assign drop_add   = cmd_r.size_bad || (faces_r == '1);
  assign cmd_pop    = (st_r == fshb_pkg::S_IDLE) && cmd_valid;
  assign res_valid  = (st_r == fshb_pkg::S_EMIT);

  always_comb begin
    res.bin_index      = ridx_r;
    res.bin_max_size   = rsz_r;
    res.bin_face_count = fshb_pkg::OUT_CNT_W'(rcnt_r);
    res.total_bins     = stored_r;
    res.last           = rlast_r;
    res.overflow       = dropped_r;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      fshb_pkg::S_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            fshb_pkg::OP_ADD: st_nxt = fshb_pkg::S_ADD_WR;
            fshb_pkg::OP_BUILD, fshb_pkg::OP_MAP, fshb_pkg::OP_QUERY:
              st_nxt = built_r ? fshb_pkg::S_DISP : fshb_pkg::S_BM1;
            default: st_nxt = fshb_pkg::S_EMIT;
          endcase
        end
      end
      fshb_pkg::S_ADD_WR: st_nxt = fshb_pkg::S_EMIT;
      fshb_pkg::S_BM1:    st_nxt = fshb_pkg::S_BM2;
      fshb_pkg::S_BM2:    st_nxt = fshb_pkg::S_BCMP;
      fshb_pkg::S_BCMP:   st_nxt = ratio_gt ? fshb_pkg::S_WRD : fshb_pkg::S_DISP;
      fshb_pkg::S_WRD:    st_nxt = fshb_pkg::S_WEV;
      fshb_pkg::S_WEV: begin
        priority if (slot_cnt != '0) begin
          st_nxt = (run_cnt_r != '0) ? fshb_pkg::S_WM1 : fshb_pkg::S_WACC;
        end else if (slot_last) begin
          st_nxt = fshb_pkg::S_WEND;
        end else begin
          st_nxt = fshb_pkg::S_WRD;
        end
      end
      fshb_pkg::S_WM1:  st_nxt = fshb_pkg::S_WM2;
      fshb_pkg::S_WM2:  st_nxt = fshb_pkg::S_WCMP;
      fshb_pkg::S_WCMP: st_nxt = fshb_pkg::S_WACC;
      fshb_pkg::S_WACC: st_nxt = slot_last ? fshb_pkg::S_WEND : fshb_pkg::S_WRD;
      fshb_pkg::S_WEND: st_nxt = fshb_pkg::S_DISP;
      fshb_pkg::S_DISP: begin
        unique case (cmd_r.op)
          fshb_pkg::OP_BUILD: st_nxt = fshb_pkg::S_ERD;
          fshb_pkg::OP_MAP:   st_nxt = fshb_pkg::S_MRD;
          default: st_nxt = ({1'b0, cmd_r.bin_number} < stored_r) ?
                            fshb_pkg::S_QRD : fshb_pkg::S_EMIT;
        endcase
      end
      fshb_pkg::S_ERD:  st_nxt = fshb_pkg::S_EOUT;
      fshb_pkg::S_EOUT: st_nxt = fshb_pkg::S_EMIT;
      fshb_pkg::S_MRD:  st_nxt = fshb_pkg::S_MCHK;
      fshb_pkg::S_MCHK: begin
        if (cmd_r.fsz <= b_size || 7'(i_r) + 7'd1 == stored_r) begin
          st_nxt = fshb_pkg::S_EMIT;
        end else begin
          st_nxt = fshb_pkg::S_MRD;
        end
      end
      fshb_pkg::S_QRD:  st_nxt = fshb_pkg::S_QOUT;
      fshb_pkg::S_QOUT: st_nxt = fshb_pkg::S_EMIT;
      fshb_pkg::S_EMIT: begin
        if (res_ready) begin
          st_nxt = (cmd_r.op == fshb_pkg::OP_BUILD && !rlast_r) ?
                   fshb_pkg::S_ERD : fshb_pkg::S_IDLE;
        end
      end
      default: st_nxt = fshb_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt = cmd_r;     vld_nxt = vld_r;       faces_nxt = faces_r;
    sum_nxt = sum_r;     largest_nxt = largest_r; stored_nxt = stored_r;
    built_nxt = built_r; dropped_nxt = dropped_r; s_nxt = s_r;
    i_nxt = i_r;         pa_nxt = pa_r;         pb_nxt = pb_r;
    run_cnt_nxt = run_cnt_r; run_sum_nxt = run_sum_r; prev_nxt = prev_r;
    c_nxt = c_r;         ridx_nxt = ridx_r;     rsz_nxt = rsz_r;
    rcnt_nxt = rcnt_r;   rlast_nxt = rlast_r;
    cw_we = 1'b0; cw_addr = cmd_r.fsz[SB-1:0]; cw_data = slot_cnt + 1'b1;
    c_re = 1'b0;
    bw_we = 1'b0; bw_addr = stored_r[fshb_pkg::BIN_AW-1:0];
    bw_data = {largest_r, run_cnt_r};
    b_re = 1'b0; br_addr = i_r;
    unique case (st_r)
      fshb_pkg::S_IDLE: begin
        c_re      = cmd_valid;
        cmd_nxt   = cmd;
        ridx_nxt  = '0;
        rsz_nxt   = '0;
        rcnt_nxt  = '0;
        rlast_nxt = 1'b1;
        if (cmd_valid && cmd.op == fshb_pkg::OP_CLEAR) begin
          vld_nxt = '0; faces_nxt = '0; sum_nxt = '0; largest_nxt = '0;
          stored_nxt = '0; built_nxt = 1'b0; dropped_nxt = 1'b0;
        end
      end
      fshb_pkg::S_ADD_WR: begin
        if (drop_add) begin
          dropped_nxt = 1'b1;
        end else begin
          cw_we = 1'b1;
          vld_nxt[cw_addr] = 1'b1;
          faces_nxt = faces_r + 1'b1;
          sum_nxt   = sum_r + SW'(cmd_r.fsz);
          if (cmd_r.fsz > largest_r) begin
            largest_nxt = cmd_r.fsz;
          end
        end
      end
      fshb_pkg::S_BM1: begin
        pa_nxt     = PAW'(largest_r * faces_r);
        stored_nxt = '0;
      end
      fshb_pkg::S_BM2: pb_nxt = PBW'(master_tol * sum_r);
      fshb_pkg::S_BCMP: begin
        s_nxt = '0; run_cnt_nxt = '0; run_sum_nxt = '0; prev_nxt = '0;
        if (!ratio_gt) begin
          bw_we = 1'b1; bw_addr = '0; bw_data = {largest_r, faces_r};
          stored_nxt = 7'd1; built_nxt = 1'b1;
        end
      end
      fshb_pkg::S_WRD: c_re = 1'b1;
      fshb_pkg::S_WEV: begin
        c_nxt = slot_cnt;
        if (slot_cnt == '0 && !slot_last) begin
          s_nxt = s_r + 1'b1;
        end
      end
      fshb_pkg::S_WM1: pa_nxt = PAW'(s_val * run_cnt_r);
      fshb_pkg::S_WM2: pb_nxt = PBW'(slave_eff * run_sum_r);
      fshb_pkg::S_WCMP: begin
        if (ratio_gt) begin
          bw_data = {prev_r, run_cnt_r};
          if (store_room) begin
            bw_we = 1'b1;
            stored_nxt = stored_r + 1'b1;
          end
          run_cnt_nxt = '0;
          run_sum_nxt = '0;
        end
      end
      fshb_pkg::S_WACC: begin
        run_sum_nxt = run_sum_r + SW'(s_val * c_r);
        run_cnt_nxt = run_cnt_r + c_r;
        prev_nxt    = s_val;
        if (!slot_last) begin
          s_nxt = s_r + 1'b1;
        end
      end
      fshb_pkg::S_WEND: begin
        if (store_room) begin
          bw_we = 1'b1;
          stored_nxt = stored_r + 1'b1;
        end
        built_nxt = 1'b1;
      end
      fshb_pkg::S_DISP: begin
        i_nxt    = '0;
        ridx_nxt = cmd_r.bin_number;
      end
      fshb_pkg::S_ERD, fshb_pkg::S_MRD: b_re = 1'b1;
      fshb_pkg::S_EOUT: begin
        ridx_nxt = i_r; rsz_nxt = b_size; rcnt_nxt = b_cnt;
        rlast_nxt = (7'(i_r) + 7'd1 == stored_r);
      end
      fshb_pkg::S_MCHK: begin
        if (cmd_r.fsz <= b_size) begin
          ridx_nxt = i_r; rsz_nxt = b_size; rcnt_nxt = b_cnt;
        end else begin
          i_nxt = i_r + 1'b1;
          ridx_nxt = '0;
        end
      end
      fshb_pkg::S_QRD: begin
        b_re = 1'b1;
        br_addr = cmd_r.bin_number;
      end
      fshb_pkg::S_QOUT: begin
        rsz_nxt = b_size; rcnt_nxt = b_cnt;
      end
      fshb_pkg::S_EMIT: begin
        if (res_ready && cmd_r.op == fshb_pkg::OP_BUILD && !rlast_r) begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  s_r <= s_nxt;  i_r <= i_nxt;  pa_r <= pa_nxt;  pb_r <= pb_nxt;
    run_cnt_r <= run_cnt_nxt;  run_sum_r <= run_sum_nxt;  prev_r <= prev_nxt;
    c_r <= c_nxt;  ridx_r <= ridx_nxt;  rsz_r <= rsz_nxt;  rcnt_r <= rcnt_nxt;
    rlast_r <= rlast_nxt;
    if (!rst_n) begin
      st_r <= fshb_pkg::S_IDLE;
      vld_r <= '0;  faces_r <= '0;  sum_r <= '0;  largest_r <= '0;
      stored_r <= '0;  built_r <= 1'b0;  dropped_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      vld_r <= vld_nxt;  faces_r <= faces_nxt;  sum_r <= sum_nxt;
      largest_r <= largest_nxt;  stored_r <= stored_nxt;
      built_r <= built_nxt;  dropped_r <= dropped_nxt;
    end
  end

  `FSHB_ASSERT(a_stored_bound, clk, rst_n, stored_r <= 7'(fshb_pkg::MAX_BINS))
  `FSHB_ASSERT(a_built_has_bin, clk, rst_n, !built_r || stored_r != '0)
  `FSHB_ASSERT_NEXT(a_pop_starts, clk, rst_n, cmd_pop, st_r != fshb_pkg::S_IDLE)
endmodule

// ----- src/face_size_histogram_binner_top.sv -----
// Top level of the face size histogram binner: config registers, result queue.
// Depends on fshb_pkg, fshb_front and fshb_back.
//
// Face size histogram binner. Add items count face sizes into a histogram;
// build groups sizes into at most 64 bins and emits every stored bin in index
// order; map and bin-size queries build silently first if needed and return
// one result; clear empties everything. An add is one read-modify-write of
// the count RAM. In the multi-bin case a build walks the size slots in turn
// through the count RAM and its shared multiply/compare. Each emitted bin
// takes a bin RAM read and an output. A map query scans the bins in index
// order. A two-entry command queue takes items while the back end works, and
// a two-entry result queue holds finished results while the consumer stalls.
// The configuration port is always ready; write only while the block is idle.
module face_size_histogram_binner_top #(
  parameter int SIZE_SLOTS = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [fshb_pkg::KIND_W-1:0]   in_kind,
  input  logic [fshb_pkg::SIZE_W-1:0]   in_face_size,
  input  logic [fshb_pkg::SIZE_W-1:0]   in_bin_number,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [fshb_pkg::SIZE_W-1:0]   out_bin_index,
  output logic [fshb_pkg::SIZE_W-1:0]   out_bin_max_size,
  output logic [fshb_pkg::OUT_CNT_W-1:0] out_bin_face_count,
  output logic [fshb_pkg::TOT_W-1:0]    out_total_bins,
  output logic                          out_last,
  output logic                          out_overflow,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fshb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fshb_pkg::TOL_W-1:0]    cfg_data
);
  logic [fshb_pkg::TOL_W-1:0] master_r, slave_r;
  logic           cmd_valid, cmd_pop, res_valid, res_ready;
  fshb_pkg::cmd_t cmd;
  fshb_pkg::res_t res, head;
  fshb_pkg::res_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           res_xfer, pop_xfer;

  // Tolerance registers; writes to unknown indexes are ignored.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= fshb_pkg::MASTER_RST;
      slave_r  <= fshb_pkg::SLAVE_RST;
    end else if (cfg_valid) begin
      if (cfg_index == fshb_pkg::REG_MASTER) begin
        master_r <= cfg_data;
      end
      if (cfg_index == fshb_pkg::REG_SLAVE) begin
        slave_r <= cfg_data;
      end
    end
  end

  fshb_front #(.SIZE_SLOTS(SIZE_SLOTS)) u_front (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_face_size, .in_bin_number,
    .cmd_valid, .cmd, .cmd_pop
  );

  fshb_back #(.SIZE_SLOTS(SIZE_SLOTS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop,
    .master_tol(master_r), .slave_tol(slave_r),
    .res_valid, .res, .res_ready
  );

  // Result queue: back end transfers in, consumer pops the oldest.
  assign res_ready = (cnt_r != 2'd2);
  assign res_xfer  = res_valid && res_ready;
  assign out_empty = (cnt_r == 2'd0);
  assign pop_xfer  = out_pop && !out_empty;
  assign head      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (res_xfer) begin
      q_r[wp_r] <= res;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (res_xfer) begin
        wp_r <= ~wp_r;
      end
      if (pop_xfer) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(res_xfer) - 2'(pop_xfer);
    end
  end

  assign out_bin_index      = head.bin_index;
  assign out_bin_max_size   = head.bin_max_size;
  assign out_bin_face_count = head.bin_face_count;
  assign out_total_bins     = head.total_bins;
  assign out_last           = head.last;
  assign out_overflow       = head.overflow;
endmodule
